FILE: rtl/spla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spla_pkg: shared types and constants for the Poisson log-likelihood block
// Holds the operation codes, field widths and the queue entry type.
// ----------------------------------------------------------------------------
package spla_pkg;

  localparam int MAX_COUNT_DEF = 1024;
  localparam int FRAC_BITS_DEF = 16;

  localparam int CNT_W   = 10;
  localparam int VAL_W   = 24;
  localparam int LF_W    = 29;
  localparam int ACC_W   = 48;
  localparam int RATIO_W = 48;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // One classified beat handed from the front end to the datapath.
  typedef struct packed {
    logic             use_term;
    logic             last;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] slice;
    logic [VAL_W-1:0] scale;
  } spla_job_t;

endpackage : spla_pkg
`default_nettype wire

FILE: rtl/spla_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spla_front: input classifier
// Takes input beats, writes table loads, queues accumulate jobs.
// ----------------------------------------------------------------------------
module spla_front
  import spla_pkg::*;
#(
  parameter int MAX_COUNT = MAX_COUNT_DEF,
  parameter int DEPTH     = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          op,
  input  wire logic                          masked,
  input  wire logic [CNT_W-1:0]              count,
  input  wire logic [VAL_W-1:0]              slice,
  input  wire logic [VAL_W-1:0]              scale,
  input  wire logic [LF_W-1:0]               lf_value,
  input  wire logic                          last,
  output logic                               tbl_we,
  output logic [$clog2(MAX_COUNT)-1:0]       tbl_waddr,
  output logic [LF_W-1:0]                    tbl_wdata,
  output logic                               job_valid,
  input  wire logic                          job_take,
  output spla_job_t                          job
);
  localparam int AW = $clog2(MAX_COUNT);
  localparam int PW = $clog2(DEPTH);

  spla_job_t        q_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [PW:0]      cnt_r;
  logic             acc_in;

  // A table load waits until every queued pixel has read its table entry.
  assign in_ready  = (cnt_r != (PW+1)'(DEPTH)) &&
                     ((op == OP_ACCUM) || (cnt_r == '0));
  assign acc_in    = in_valid && in_ready && (op == OP_ACCUM);
  assign tbl_we    = in_valid && in_ready && (op == OP_LOAD) &&
                     ({{(32-CNT_W){1'b0}}, count} < MAX_COUNT);
  assign tbl_waddr = AW'(count);
  assign tbl_wdata = lf_value;
  assign job_valid = (cnt_r != '0);
  assign job       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (acc_in) begin
      q_r[wp_r] <= '{use_term: !masked && (slice != '0), last: last,
                     count: count, slice: slice, scale: scale};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (acc_in) wp_r <= PW'(wp_r + 1'b1);
      if (job_take) rp_r <= PW'(rp_r + 1'b1);
      cnt_r <= cnt_r + (PW+1)'(acc_in) - (PW+1)'(job_take);
    end
  end
endmodule : spla_front
`default_nettype wire

FILE: rtl/spla_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spla_back: sequential term datapath
// Restoring divide, square-and-compare log2, scaled ln, table read and a
// saturating accumulate, one step per cycle under a one-hot sequencer.
// ----------------------------------------------------------------------------
module spla_back
  import spla_pkg::*;
#(
  parameter int MAX_COUNT = MAX_COUNT_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     tbl_we,
  input  wire logic [$clog2(MAX_COUNT)-1:0] tbl_waddr,
  input  wire logic [LF_W-1:0]          tbl_wdata,
  input  wire logic                     job_valid,
  output logic                          job_take,
  input  wire spla_job_t                job,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output logic [ACC_W-1:0]              res_sum,
  output logic                          res_sat
);
  localparam int AW  = $clog2(MAX_COUNT);
  localparam int NW  = VAL_W + FRAC_BITS;   // dividend width
  localparam int DCW = $clog2(NW + 1);
  localparam int FCW = $clog2(FRAC_BITS + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_DIV  = 8'b00000010,
    S_NORM = 8'b00000100,
    S_LOG  = 8'b00001000,
    S_LN   = 8'b00010000,
    S_MUL  = 8'b00100000,
    S_ACC  = 8'b01000000,
    S_OUT  = 8'b10000000
  } st_t;

  st_t st_r, st_nxt;

  logic [LF_W-1:0]    mem [MAX_COUNT];
  logic [LF_W-1:0]    lf_r;
  spla_job_t          job_r;
  logic [NW-1:0]      quo_r;
  logic [VAL_W:0]     rem_r;
  logic [DCW-1:0]     dcnt_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [5:0]         p_r;
  logic [32:0]        m_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [FCW-1:0]     fcnt_r;
  logic [63:0]        ln_r;
  logic [63:0]        term_r;
  logic signed [ACC_W-1:0] sum_r;
  logic               sat_r;
  logic               out_v_r;
  logic [ACC_W-1:0]   out_sum_r;
  logic               out_sat_r;

  logic [VAL_W-1:0]   divisor;
  logic [VAL_W:0]     rem_sh;
  logic [5:0]         msb;
  logic [65:0]        sq;
  logic [32:0]        sq_m;
  logic signed [31:0] l2;
  logic [31:0]        mag;
  logic [63:0]        prod;
  logic [AW-1:0]      raddr;
  logic signed [ACC_W+1:0] wide_sum;

  assign divisor = (job_r.scale == '0) ? VAL_W'(1) : job_r.scale;
  assign rem_sh  = {rem_r[VAL_W-1:0], quo_r[NW-1]};
  assign raddr   = ({{(32-CNT_W){1'b0}}, job.count} < MAX_COUNT) ?
                   AW'(job.count) : AW'(MAX_COUNT - 1);

  always_comb begin
    msb = '0;
    for (int i = 0; i < RATIO_W; i++) begin
      if (ratio_r[i]) msb = 6'(i);
    end
  end

  assign sq   = 66'(m_r) * 66'(m_r);
  assign sq_m = 33'(sq >> 31);
  assign l2   = (32'(p_r) - 32'(FRAC_BITS)) * (32'sd1 <<< FRAC_BITS) + 32'(frac_r);
  assign mag  = l2[31] ? 32'(-l2) : 32'(l2);
  assign prod = 64'(mag) * 64'(LN2_Q32);
  assign wide_sum = (ACC_W+2)'(sum_r) + (ACC_W+2)'($signed(term_r));

  assign job_take  = (st_r == S_IDLE) && job_valid;
  assign res_valid = out_v_r;
  assign res_sum   = out_sum_r;
  assign res_sat   = out_sat_r;

  always_ff @(posedge clk) begin
    if (tbl_we) mem[tbl_waddr] <= tbl_wdata;
    if (job_take) lf_r <= mem[raddr];
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (job_valid) st_nxt = job.use_term ? S_DIV : S_OUT;
      S_DIV:  if (dcnt_r == DCW'(NW - 1)) st_nxt = S_NORM;
      S_NORM: st_nxt = S_LOG;
      S_LOG:  if (fcnt_r == FCW'(FRAC_BITS - 1)) st_nxt = S_LN;
      S_LN:   st_nxt = S_MUL;
      S_MUL:  st_nxt = S_ACC;
      S_ACC:  st_nxt = S_OUT;
      S_OUT:  if (!job_r.last || !out_v_r || res_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        job_r  <= job;
        quo_r  <= NW'({job.slice, {FRAC_BITS{1'b0}}});
        rem_r  <= '0;
        dcnt_r <= '0;
        fcnt_r <= '0;
        frac_r <= '0;
      end
      S_DIV: begin
        dcnt_r <= DCW'(dcnt_r + 1'b1);
        if (rem_sh >= {1'b0, divisor}) begin
          rem_r <= rem_sh - {1'b0, divisor};
          quo_r <= {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          quo_r <= {quo_r[NW-2:0], 1'b0};
        end
        if (dcnt_r == DCW'(NW - 1)) begin
          ratio_r <= RATIO_W'({quo_r[NW-2:0], (rem_sh >= {1'b0, divisor})});
        end
      end
      S_NORM: begin
        if (ratio_r == '0) ratio_r <= RATIO_W'(1);
        p_r <= (ratio_r == '0) ? 6'd0 : msb;
        if (ratio_r == '0) m_r <= 33'h080000000;
        else if (msb >= 6'd31) m_r <= 33'(ratio_r >> (msb - 6'd31));
        else m_r <= 33'(ratio_r << (6'd31 - msb));
      end
      S_LOG: begin
        fcnt_r <= FCW'(fcnt_r + 1'b1);
        frac_r <= {frac_r[FRAC_BITS-2:0], sq_m[32]};
        m_r    <= sq_m[32] ? (sq_m >> 1) : sq_m;
      end
      S_LN: begin
        ln_r <= l2[31] ? -64'((prod + 64'h80000000) >> 32)
                       :  64'((prod + 64'h80000000) >> 32);
      end
      S_MUL: begin
        term_r <= 64'(-$signed({16'd0, ratio_r}))
                + 64'($signed({1'b0, job_r.count}) * $signed(ln_r))
                - 64'(lf_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      sum_r   <= '0;
      sat_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_ACC) begin
        if (wide_sum > (ACC_W+2)'(signed'({2'b00, {(ACC_W-1){1'b1}}}))) begin
          sum_r <= {1'b0, {(ACC_W-1){1'b1}}};
          sat_r <= 1'b1;
        end else if (wide_sum < -((ACC_W+2)'(signed'({3'b001, {(ACC_W-1){1'b0}}})))) begin
          sum_r <= {1'b1, {(ACC_W-1){1'b0}}};
          sat_r <= 1'b1;
        end else begin
          sum_r <= ACC_W'(wide_sum);
        end
      end
      if ((st_r == S_OUT) && (st_nxt == S_IDLE) && job_r.last) begin
        out_v_r   <= 1'b1;
        out_sum_r <= sum_r;
        out_sat_r <= sat_r;
        sum_r     <= '0;
        sat_r     <= 1'b0;
      end else if (out_v_r && res_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end
endmodule : spla_back
`default_nettype wire

FILE: rtl/scaled_poisson_loglik_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scaled_poisson_loglik_accumulator: Poisson log-likelihood accumulator
// Sums -r + n*ln(r) - logfact[n], r = slice/scaling, over a pixel run.
// ----------------------------------------------------------------------------
// Usage: beats enter on the in_ channel. in_tuser selects the operation
// (0 accumulates one pixel, 1 writes one log-factorial table entry). in_tlast
// marks the final pixel of a pattern-slice pair; on that beat the block sends
// one out_ beat carrying the signed Q31.16 sum and, in out_tuser, a flag that
// says the sum clipped during the pair. The sum is then cleared.
// A front end sorts the beats: accumulate beats go into a
// four-entry queue, and a table load is held off until that queue has
// drained, then written at once. The back end works one pixel at a time:
// a radix-2 restoring divide of 40 steps, one normalize step, FRAC_BITS
// square-and-compare log steps, then ln scaling, multiply and accumulate.
// A skipped pixel bypasses all of these steps.
// The result sits in an output register; while the receiver stalls, the
// back end holds on the next last pixel and the queue still fills.
// Reset clears the sum, the clip flag and the queue; the table is not
// cleared and entries never written read as undefined.
module scaled_poisson_loglik_accumulator
  import spla_pkg::*;
#(
  parameter int MAX_COUNT = MAX_COUNT_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [0] pixel_masked, [10:1] photon_count, [34:11] slice_value,
  // [58:35] scaling, [87:59] log_factorial_value, [95:88] zero
  input  wire logic [95:0]  in_tdata,
  input  wire logic         in_tuser,   // [0] operation
  input  wire logic         in_tlast,   // last_pixel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [47:0]       out_tdata,  // [47:0] log_likelihood
  output logic              out_tuser   // [0] saturated
);
  logic                         tbl_we;
  logic [$clog2(MAX_COUNT)-1:0] tbl_waddr;
  logic [LF_W-1:0]              tbl_wdata;
  logic                         job_valid;
  logic                         job_take;
  spla_job_t                    job;

  spla_front #(.MAX_COUNT(MAX_COUNT), .DEPTH(4)) u_front (
    .clk, .rst_n,
    .in_valid (in_tvalid), .in_ready (in_tready),
    .op       (in_tuser),
    .masked   (in_tdata[0]),
    .count    (in_tdata[10:1]),
    .slice    (in_tdata[34:11]),
    .scale    (in_tdata[58:35]),
    .lf_value (in_tdata[87:59]),
    .last     (in_tlast),
    .tbl_we, .tbl_waddr, .tbl_wdata,
    .job_valid, .job_take, .job
  );

  spla_back #(.MAX_COUNT(MAX_COUNT), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n,
    .tbl_we, .tbl_waddr, .tbl_wdata,
    .job_valid, .job_take, .job,
    .res_valid (out_tvalid), .res_ready (out_tready),
    .res_sum   (out_tdata), .res_sat (out_tuser)
  );

`ifndef ASSERT_OFF
  // The queue never hands out a job it does not hold.
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> job_valid) else $error("job taken from empty queue");
  // A pending result is not replaced while stalled.
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed under stall");
`endif
endmodule : scaled_poisson_loglik_accumulator
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for scaled_poisson_loglik_accumulator
// Streams table loads and pixel beats into the block, predicts each pair sum
// and clip flag in fixed point, and compares every output beat in order.
// ----------------------------------------------------------------------------
module tb;
  import spla_pkg::*;

  localparam int  FB        = FRAC_BITS_DEF;
  localparam int  LIMIT     = 900000;
  localparam int  HOLD_LEN  = 3000;
  localparam longint ACC_HI = 64'sd140737488355327;
  localparam longint ACC_LO = -64'sd140737488355328;

  typedef struct {
    logic             op;
    logic             masked;
    logic             last;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] slice;
    logic [VAL_W-1:0] scale;
    logic [LF_W-1:0]  lf;
  } pixel_beat_t;

  typedef struct {
    logic [ACC_W-1:0] sum;
    logic             clip;
  } pair_sum_t;

  // Keeps its own copy of the running sum, clip flag and log-factorial table,
  // and queues the sum expected at the end of every pixel run.
  class loglik_scoreboard;
    longint           acc;
    bit               clip;
    logic [LF_W-1:0]  lf_table [MAX_COUNT_DEF];
    pair_sum_t        sums_due [$];
    int               errors;
    int               pairs_seen;
    int               clipped_pairs;

    function new();
      acc = 0;
      clip = 0;
      errors = 0;
      pairs_seen = 0;
      clipped_pairs = 0;
    endfunction

    function automatic logic [63:0] ratio(logic [63:0] s, logic [63:0] c);
      logic [63:0] r;
      if (c == 0) c = 1;
      r = (s << FB) / c;
      if (r == 0) r = 1;
      return r;
    endfunction

    // Natural log via log2 by repeated squaring of the normalized mantissa.
    function automatic longint ln_q(logic [63:0] r);
      int          msb;
      logic [63:0] m, frac, mag, t;
      longint      l2;
      msb = 0;
      frac = 0;
      for (int i = 0; i < 64; i++) if (r[i]) msb = i;
      m = (msb >= 31) ? (r >> (msb - 31)) : (r << (31 - msb));
      for (int i = 0; i < FB; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if ((m >> 32) != 0) begin
          frac = frac | 1;
          m = m >> 1;
        end
      end
      l2 = (longint'(msb) - FB) * (64'sd1 << FB) + longint'(frac);
      mag = (l2 < 0) ? 64'(-l2) : 64'(l2);
      t = (mag * 64'(LN2_Q32) + (64'd1 << 31)) >> 32;
      return (l2 < 0) ? -longint'(t) : longint'(t);
    endfunction

    function void note_input(pixel_beat_t b);
      logic [63:0] r;
      longint      term, nxt;
      pair_sum_t   e;
      if (b.op == OP_LOAD) begin
        lf_table[b.count] = b.lf;
        return;
      end
      if (!b.masked && b.slice != 0) begin
        r = ratio(64'(b.slice), 64'(b.scale));
        term = -longint'(r) + longint'(b.count) * ln_q(r) - longint'(lf_table[b.count]);
        nxt = acc + term;
        if (nxt > ACC_HI) begin
          nxt = ACC_HI;
          clip = 1;
        end else if (nxt < ACC_LO) begin
          nxt = ACC_LO;
          clip = 1;
        end
        acc = nxt;
      end
      if (b.last) begin
        e.sum = acc[ACC_W-1:0];
        e.clip = clip;
        sums_due.push_back(e);
        acc = 0;
        clip = 0;
      end
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [ACC_W-1:0] sum, logic sat);
      pair_sum_t e;
      if (sums_due.size() == 0) begin
        report($sformatf("unexpected output beat sum=%h", sum));
        return;
      end
      e = sums_due.pop_front();
      pairs_seen++;
      if (e.clip) clipped_pairs++;
      if (sum !== e.sum)
        report($sformatf("log_likelihood %h, expected %h", sum, e.sum));
      if (sat !== e.clip)
        report($sformatf("saturated %b, expected %b", sat, e.clip));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;
  logic        out_tuser;

  scaled_poisson_loglik_accumulator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  loglik_scoreboard sb = new();

  // Idle rates in percent for each side, changed between phases.
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  bit hold_req = 0;
  bit hold_active = 0;
  int cycles = 0;
  int beats_sent = 0;

  // Table addresses written so far; counted pixels only read these.
  bit written [MAX_COUNT_DEF];
  int written_list [$];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The receiver checks each beat taken at this edge, then decides whether to
  // be ready for the next one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if (!rst_n || hold_active) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Long receiver stall: counted here so the sender keeps offering beats and
  // the block's queue fills up behind the held result.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_active = 1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_active = 0;
        hold_req = 0;
      end
    end
  end

  // Drives one beat, waits for acceptance, then hands it to the predictor.
  task send_beat(pixel_beat_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= b.op;
    in_tlast <= b.last;
    in_tdata <= {8'd0, b.lf, b.scale, b.slice, b.count, b.masked};
    do @(posedge clk); while (!in_tready);
    sb.note_input(b);
    beats_sent++;
    if (b.op == OP_LOAD && !written[b.count]) begin
      written[b.count] = 1;
      written_list.push_back(b.count);
    end
  endtask

  task send_load(int addr, logic [LF_W-1:0] v, logic last);
    pixel_beat_t b;
    b = '{OP_LOAD, $urandom_range(1), last, CNT_W'(addr),
          VAL_W'($urandom), VAL_W'($urandom), v};
    send_beat(b);
  endtask

  task send_pixel(logic masked, int n, logic [VAL_W-1:0] s, logic [VAL_W-1:0] c,
                  logic last);
    pixel_beat_t b;
    b = '{OP_ACCUM, masked, last, CNT_W'(n), s, c, LF_W'($urandom)};
    send_beat(b);
  endtask

  // Random value of random magnitude so small and large ratios both occur.
  function automatic logic [VAL_W-1:0] spread_val();
    return VAL_W'($urandom) >> $urandom_range(VAL_W - 1);
  endfunction

  // Mostly counted pixels on written addresses, some skipped ones and loads.
  task random_beat();
    int               pick;
    logic [VAL_W-1:0] s;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_load($urandom_range(MAX_COUNT_DEF - 1),
                ($urandom_range(9) == 0) ? {LF_W{1'b1}} : LF_W'($urandom),
                $urandom_range(1));
    end else if (pick < 18) begin
      send_pixel(1'b1, $urandom_range(MAX_COUNT_DEF - 1), spread_val(),
                 spread_val(), $urandom_range(7) == 0);
    end else if (pick < 23) begin
      send_pixel(1'b0, $urandom_range(MAX_COUNT_DEF - 1), '0, spread_val(),
                 $urandom_range(7) == 0);
    end else begin
      s = spread_val();
      if (s == 0) s = 1;
      send_pixel(1'b0, written_list[$urandom_range(written_list.size() - 1)],
                 s, spread_val(), $urandom_range(7) == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: table extremes, then each special pixel case.
    send_load(0, '0, 1'b0);
    send_load(MAX_COUNT_DEF - 1, {LF_W{1'b1}}, 1'b0);
    send_load(1, 29'h0AAA_AAAA, 1'b0);
    send_load(682, 29'h1555_5555, 1'b0);
    send_load(341, 29'd1, 1'b0);
    send_pixel(1'b0, 0, {VAL_W{1'b1}}, 24'd1, 1'b0);
    send_pixel(1'b0, MAX_COUNT_DEF - 1, 24'd1, {VAL_W{1'b1}}, 1'b1);
    send_pixel(1'b0, 682, 24'h01_0000, 24'h01_0000, 1'b1);
    send_pixel(1'b0, 341, 24'h12_3456, 24'd0, 1'b1);
    send_pixel(1'b1, 682, 24'h00_1234, 24'h01_0000, 1'b1);
    send_pixel(1'b0, 1, 24'h00_8000, 24'h01_0000, 1'b0);
    send_load(1, 29'h0000_B172, 1'b1);
    send_pixel(1'b0, 1, 24'h03_0000, 24'h00_4000, 1'b0);
    send_pixel(1'b0, 5, 24'd0, 24'h01_0000, 1'b1);
    send_pixel(1'b0, MAX_COUNT_DEF - 1, {VAL_W{1'b1}}, {VAL_W{1'b1}}, 1'b1);
    send_pixel(1'b1, 0, '0, '0, 1'b1);

    // Enough large negative terms in one run to clip the sum at its minimum,
    // then a short pair to show the flag is cleared.
    for (int i = 0; i < 140; i++)
      send_pixel(1'b0, MAX_COUNT_DEF - 1, {VAL_W{1'b1}}, 24'd1, i == 139);
    send_pixel(1'b0, 682, 24'h02_0000, 24'h01_0000, 1'b1);

    for (int i = 0; i < 48; i++) send_load($urandom_range(MAX_COUNT_DEF - 1),
                                           LF_W'($urandom), 1'b0);

    sender_idle_pct = 17;
    receiver_idle_pct = 51;
    repeat (200) random_beat();
    sender_idle_pct = 51;
    receiver_idle_pct = 17;
    repeat (200) random_beat();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    repeat (80) random_beat();
    hold_req = 1;
    for (int i = 0; i < 40; i++)
      send_pixel(1'b0, written_list[$urandom_range(written_list.size() - 1)],
                 24'h01_0000 + VAL_W'($urandom_range(65535)), 24'h01_0000,
                 $urandom_range(1));
    repeat (100) random_beat();
    in_tvalid <= 1'b0;

    while (sb.sums_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d beats; checked %0d pair sums, %0d of them clipped.",
             beats_sent, sb.pairs_seen, sb.clipped_pairs);
    $display("Both sides idled in turn and the receiver stalled %0d cycles once.",
             HOLD_LEN);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/spla_pkg.sv
rtl/spla_front.sv
rtl/spla_back.sv
rtl/scaled_poisson_loglik_accumulator.sv
sim/tb.sv
